// ===== hdl/rrsg_pkg.sv =====
`timescale 1ns / 1ps
// rrsg_pkg: shared constants, register codes and structs of the rounded rectangle span generator
// no dependencies; used by every other file of the block

package rrsg_pkg;

	localparam int SIZE_BITS   = 10;
	localparam int RADIUS_BITS = 7;
	localparam int COORD_W     = 16;
	localparam int COLOR_W     = 16;
	localparam int SQ_W        = 2 * RADIUS_BITS;
	localparam int RIDX_W      = (RADIUS_BITS > 1) ? $clog2(RADIUS_BITS) : 1;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	// halves each rgb565 channel after a right shift by one
	localparam logic [COLOR_W-1:0] DIM_MASK = 16'h7BEF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RECT_LEFT     = 3'd0,
		REG_RECT_TOP      = 3'd1,
		REG_RECT_WIDTH    = 3'd2,
		REG_RECT_HEIGHT   = 3'd3,
		REG_CORNER_RADIUS = 3'd4,
		REG_FILL_COLOR    = 3'd5,
		REG_PRESSED_LOOK  = 3'd6,
		REG_SHOWN         = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [COORD_W-1:0]     rect_left;
		logic [COORD_W-1:0]     rect_top;
		logic [SIZE_BITS-1:0]   rect_width;
		logic [SIZE_BITS-1:0]   rect_height;
		logic [RADIUS_BITS-1:0] corner_radius;
		logic [COLOR_W-1:0]     fill_color;
		logic                   pressed_look;
		logic                   shown;
	} cfg_t;

	// what one square root cell hands to the next
	typedef struct packed {
		logic                   valid;
		logic [SQ_W-1:0]        val;
		logic [RADIUS_BITS-1:0] root;
	} root_step_t;

endpackage

// ===== hdl/rrsg_ifs.sv =====
`timescale 1ns / 1ps
// rrsg channel interfaces: row requests in, span requests out, configuration writes
// depends on rrsg_pkg

interface rrsg_row_if;
	logic                             valid;
	logic                             ready;
	logic [rrsg_pkg::SIZE_BITS-1:0]   row;

	modport source (output valid, output row, input ready);
	modport sink (input valid, input row, output ready);
endinterface

interface rrsg_span_if;
	logic                                    valid;
	logic                                    ready;
	logic                                    span_valid;
	logic signed [rrsg_pkg::COORD_W-1:0]     span_x;
	logic signed [rrsg_pkg::COORD_W-1:0]     span_y;
	logic [rrsg_pkg::SIZE_BITS-1:0]          span_len;
	logic [rrsg_pkg::COLOR_W-1:0]            span_color;

	modport source (output valid, output span_valid, output span_x, output span_y,
		output span_len, output span_color, input ready);
	modport sink (input valid, input span_valid, input span_x, input span_y,
		input span_len, input span_color, output ready);
endinterface

interface rrsg_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [rrsg_pkg::CFG_IDX_W-1:0]    index;
	logic [rrsg_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/rounded_rect_span_generator_core.sv =====
`timescale 1ns / 1ps
// rounded_rect_span_generator_core: top level, one fill span per row request
// depends on rrsg_pkg, rrsg_ifs, rrsg_cfg_regs and rrsg_cell

// One row request gives one span request. A row is taken only when the previous
// one has moved into the output register, so requests go one at a time: a row
// is held in the row register for the band logic, passes the chain of RADIUS_BITS
// root cells that each settle one bit of floor(sqrt(r*r - dist*dist)) per cycle,
// and then the finish stage that loads the output register. A finished span waits
// in the output register, so the next row may be taken while it is unclaimed; a
// span that cannot leave holds the finish stage and the row side until it does.
// Configuration is written through the cfg channel, which never stalls, and must
// only change while no row is in flight. Rows at or past the height, or any row
// while the rectangle is hidden, give span_valid low with all other fields zero.

module rounded_rect_span_generator_core (
	input  logic         clk,
	input  logic         arst_n,
	rrsg_row_if.sink     row_ch,
	rrsg_span_if.source  span_ch,
	rrsg_cfg_if.sink     cfg_ch
);
	import rrsg_pkg::*;

	cfg_t                   cfg;
	root_step_t             chain [RADIUS_BITS+1];

	// request bookkeeping
	logic                   accept;
	logic                   busy_q;
	logic                   start_s1;
	logic [SIZE_BITS-1:0]   row_q;
	logic                   live_q;
	logic                   band_q;

	// band detection from the held row
	logic [RADIUS_BITS-1:0] r;
	logic                   live;
	logic                   top_band;
	logic                   bot_band;
	logic [SIZE_BITS:0]     bot_sum;
	logic [SIZE_BITS:0]     bot_dist;
	logic [RADIUS_BITS-1:0] corner_dist;
	logic [SQ_W-1:0]        sq;

	// finish stage
	logic                   fin_valid_q;
	logic [RADIUS_BITS-1:0] fin_root_q;
	logic                   fin_move;
	logic [RADIUS_BITS-1:0] indent;
	logic [SIZE_BITS-1:0]   twice;
	logic [SIZE_BITS-1:0]   len;
	logic [COLOR_W-1:0]     color;

	// output register
	logic                   out_valid_q;
	logic                   span_valid_q;
	logic [COORD_W-1:0]     span_x_q;
	logic [COORD_W-1:0]     span_y_q;
	logic [SIZE_BITS-1:0]   span_len_q;
	logic [COLOR_W-1:0]     span_color_q;

	rrsg_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_ch (cfg_ch),
		.cfg    (cfg)
	);

	assign row_ch.ready = !busy_q;
	assign accept       = row_ch.valid && !busy_q;

	// head of the chain: which corner band the row falls in and how far from its edge
	assign r        = cfg.corner_radius;
	assign live     = cfg.shown && (row_q < cfg.rect_height);
	assign top_band = (r != '0) && (row_q < SIZE_BITS'(r));
	assign bot_sum  = {1'b0, row_q} + (SIZE_BITS+1)'(r);
	// bottom band only counts when the top band rule did not already claim the row
	assign bot_band = (r != '0) && !top_band && (bot_sum >= {1'b0, cfg.rect_height});
	assign bot_dist = bot_sum + (SIZE_BITS+1)'(1) - {1'b0, cfg.rect_height};
	assign corner_dist = top_band ? (r - row_q[RADIUS_BITS-1:0])
		: bot_dist[RADIUS_BITS-1:0];
	assign sq       = SQ_W'(r) * SQ_W'(r) - SQ_W'(corner_dist) * SQ_W'(corner_dist);

	assign chain[0] = '{valid: start_s1, val: sq, root: '0};

	// one cell per root bit, most significant bit first
	for (genvar i = 0; i < RADIUS_BITS; i++) begin : g_cell
		rrsg_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.bit_pos   (RIDX_W'(RADIUS_BITS - 1 - i)),
			.prev_step (chain[i]),
			.nxt_step  (chain[i+1])
		);
	end

	// finish: indent, clamped length, wrapped coordinates, color dimmed when pressed_look is set
	assign fin_move = fin_valid_q && (!out_valid_q || span_ch.ready);
	assign indent   = band_q ? (r - fin_root_q) : '0;
	assign twice    = SIZE_BITS'({indent, 1'b0});
	assign len      = (cfg.rect_width > twice) ? (cfg.rect_width - twice) : '0;
	assign color    = cfg.pressed_look ? ((cfg.fill_color >> 1) & DIM_MASK) : cfg.fill_color;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			start_s1    <= 1'b0;
			fin_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_s1 <= accept;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (fin_move) begin
				busy_q <= 1'b0;
			end
			if (chain[RADIUS_BITS].valid) begin
				fin_valid_q <= 1'b1;
			end else if (fin_move) begin
				fin_valid_q <= 1'b0;
			end
			if (fin_move) begin
				out_valid_q <= 1'b1;
			end else if (span_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_q <= row_ch.row;
		end
		if (start_s1) begin
			live_q <= live;
			band_q <= top_band || bot_band;
		end
		if (chain[RADIUS_BITS].valid) begin
			fin_root_q <= chain[RADIUS_BITS].root;
		end
		if (fin_move) begin
			span_valid_q <= live_q;
			span_x_q     <= live_q ? (cfg.rect_left + COORD_W'(indent)) : '0;
			span_y_q     <= live_q ? (cfg.rect_top + COORD_W'(row_q)) : '0;
			span_len_q   <= live_q ? len : '0;
			span_color_q <= live_q ? color : '0;
		end
	end

	assign span_ch.valid      = out_valid_q;
	assign span_ch.span_valid = span_valid_q;
	assign span_ch.span_x     = $signed(span_x_q);
	assign span_ch.span_y     = $signed(span_y_q);
	assign span_ch.span_len   = span_len_q;
	assign span_ch.span_color = span_color_q;

endmodule

// ===== hdl/rrsg_cfg_regs.sv =====
`timescale 1ns / 1ps
// rrsg_cfg_regs: configuration register file written over the cfg channel
// depends on rrsg_pkg and rrsg_ifs

module rrsg_cfg_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	rrsg_cfg_if.sink             cfg_ch,
	output rrsg_pkg::cfg_t       cfg
);
	import rrsg_pkg::*;

	cfg_t cfg_q;

	assign cfg_ch.ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{rect_left: '0, rect_top: '0, rect_width: '0, rect_height: '0,
				corner_radius: '0, fill_color: '0, pressed_look: 1'b0, shown: 1'b1};
		end else if (cfg_ch.valid) begin
			unique case (cfg_reg_t'(cfg_ch.index))
				REG_RECT_LEFT:     cfg_q.rect_left     <= cfg_ch.data[COORD_W-1:0];
				REG_RECT_TOP:      cfg_q.rect_top      <= cfg_ch.data[COORD_W-1:0];
				REG_RECT_WIDTH:    cfg_q.rect_width    <= cfg_ch.data[SIZE_BITS-1:0];
				REG_RECT_HEIGHT:   cfg_q.rect_height   <= cfg_ch.data[SIZE_BITS-1:0];
				REG_CORNER_RADIUS: cfg_q.corner_radius <= cfg_ch.data[RADIUS_BITS-1:0];
				REG_FILL_COLOR:    cfg_q.fill_color    <= cfg_ch.data[COLOR_W-1:0];
				REG_PRESSED_LOOK:  cfg_q.pressed_look  <= cfg_ch.data[0];
				REG_SHOWN:         cfg_q.shown         <= cfg_ch.data[0];
				default: ;
			endcase
		end
	end

endmodule

// ===== hdl/rrsg_cell.sv =====
`timescale 1ns / 1ps
// rrsg_cell: one bit of the integer square root, registered toward the next cell
// depends on rrsg_pkg

module rrsg_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [rrsg_pkg::RIDX_W-1:0]   bit_pos,
	input  rrsg_pkg::root_step_t          prev_step,
	output rrsg_pkg::root_step_t          nxt_step
);
	import rrsg_pkg::*;

	logic [RADIUS_BITS-1:0] trial;
	logic [SQ_W-1:0]        trial_sq;
	logic                   valid_q;
	logic [SQ_W-1:0]        val_q;
	logic [RADIUS_BITS-1:0] root_q;

	// try setting this bit, keep it if the square still fits
	assign trial    = prev_step.root | (RADIUS_BITS'(1) << bit_pos);
	assign trial_sq = SQ_W'(trial) * SQ_W'(trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= prev_step.valid;
		end
	end

	always_ff @(posedge clk) begin
		val_q  <= prev_step.val;
		root_q <= (trial_sq <= prev_step.val) ? trial : prev_step.root;
	end

	assign nxt_step = '{valid: valid_q, val: val_q, root: root_q};

endmodule

// ===== hdl/rrsg_checker.sv =====
`timescale 1ns / 1ps
// rrsg_checker: port level assertions of the span generator, bound to the top level
// depends on rrsg_pkg and rounded_rect_span_generator_core

module rrsg_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  row_valid,
	input logic                                  row_ready,
	input logic                                  span_req_valid,
	input logic                                  span_req_ready,
	input logic                                  span_valid,
	input logic signed [rrsg_pkg::COORD_W-1:0]   span_x,
	input logic signed [rrsg_pkg::COORD_W-1:0]   span_y,
	input logic [rrsg_pkg::SIZE_BITS-1:0]        span_len,
	input logic [rrsg_pkg::COLOR_W-1:0]          span_color
);
	import rrsg_pkg::*;

	// a taken row keeps the block busy for at least the next cycle
	a_busy_after_row: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && row_ready |=> !row_ready)
		else $error("row request taken while the previous one is still in flight");

	// a row needs the whole chain, so no new span can show right after it is taken
	a_no_instant_span: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && row_ready && !span_req_valid |=> !span_req_valid)
		else $error("span request appeared one cycle after its row");

	// an invalid span carries zeros in every field
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		span_req_valid && !span_valid |-> span_x == '0 && span_y == '0
			&& span_len == '0 && span_color == '0)
		else $error("invalid span with nonzero fields");

	// a stalled span request holds its payload
	a_span_hold: assert property (@(posedge clk) disable iff (!arst_n)
		span_req_valid && !span_req_ready |=> span_req_valid && $stable(span_x)
			&& $stable(span_y) && $stable(span_len) && $stable(span_color))
		else $error("span request changed while stalled");

endmodule

bind rounded_rect_span_generator_core rrsg_checker u_rrsg_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.row_valid      (row_ch.valid),
	.row_ready      (row_ch.ready),
	.span_req_valid (span_ch.valid),
	.span_req_ready (span_ch.ready),
	.span_valid     (span_ch.span_valid),
	.span_x         (span_ch.span_x),
	.span_y         (span_ch.span_y),
	.span_len       (span_ch.span_len),
	.span_color     (span_ch.span_color)
);
